### src/ptfc_pkg.sv
// Shared types and constants for the periodic timer with free-running counter.
// Used by ptfc_core, the top level and the port checker; no dependencies.
package ptfc_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [5:0]  addr;
    logic [31:0] wdata;
  } cmd_t;

  // Register word indexes
  localparam logic [5:0] REG_LOAD    = 6'd0;
  localparam logic [5:0] REG_VALUE   = 6'd1;
  localparam logic [5:0] REG_CONTROL = 6'd2;
  localparam logic [5:0] REG_INTCLR  = 6'd3;
  localparam logic [5:0] REG_RAWIRQ  = 6'd4;
  localparam logic [5:0] REG_MASKIRQ = 6'd5;
  localparam logic [5:0] REG_RELOAD  = 6'd6;
  localparam logic [5:0] REG_PREDIV  = 6'd7;
  localparam logic [5:0] REG_FREECNT = 6'd8;

  // Control word bit positions
  localparam int unsigned CTRL_FREE32_BIT  = 1;
  localparam int unsigned CTRL_INTEN_BIT   = 5;
  localparam int unsigned CTRL_MAINEN_BIT  = 7;
  localparam int unsigned CTRL_FREEEN_BIT  = 9;

  localparam logic [1:0] PRESC_CODE_16  = 2'd1;
  localparam logic [1:0] PRESC_CODE_256 = 2'd2;

  localparam logic [31:0] ID_WORD      = 32'h544D_5241;
  localparam logic [31:0] CTRL_RESET   = 32'h000E_0020;
  localparam logic [31:0] PREDIV_RESET = 32'd125;
  localparam logic [31:0] FREE_LIM_32  = 32'hFFFF_FFFF;
  localparam logic [31:0] FREE_LIM_16  = 32'h0000_FFFF;

endpackage

### src/ptfc_core.sv
// Register file and counters of the timer: applies one word per accept.
// Depends on ptfc_pkg. Read data reflects state before the word, irq after it.
module ptfc_core #(
  parameter int REGISTER_WORDS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  ptfc_pkg::cmd_t     cmd_i,
  output logic [31:0]        rd_o,
  output logic               irq_o
);

  logic [31:0] load_q, load_d;
  logic [31:0] ctrl_q, ctrl_d;
  logic [31:0] prediv_q, prediv_d;
  logic        raw_q, raw_d;
  logic [31:0] main_q, main_d;
  logic        main_run_q, main_run_d;
  logic [31:0] prediv_cnt_q, prediv_cnt_d;
  logic [7:0]  presc_cnt_q, presc_cnt_d;
  logic [31:0] free_q, free_d;
  logic        free_run_q, free_run_d;
  logic [7:0]  fdiv_cnt_q, fdiv_cnt_d;

  logic [7:0]  presc_last;
  logic [31:0] free_lim_cur;
  logic [31:0] free_lim_new;
  logic        known;

  assign known = ({1'b0, cmd_i.addr} < 7'(REGISTER_WORDS));

  always_comb begin
    case (ctrl_q[3:2])
      ptfc_pkg::PRESC_CODE_16:  presc_last = 8'd15;
      ptfc_pkg::PRESC_CODE_256: presc_last = 8'd255;
      default:                  presc_last = 8'd0;
    endcase
  end

  assign free_lim_cur = ctrl_q[ptfc_pkg::CTRL_FREE32_BIT] ? ptfc_pkg::FREE_LIM_32
                                                           : ptfc_pkg::FREE_LIM_16;
  assign free_lim_new = cmd_i.wdata[ptfc_pkg::CTRL_FREE32_BIT] ? ptfc_pkg::FREE_LIM_32
                                                                : ptfc_pkg::FREE_LIM_16;

  always_comb begin
    load_d       = load_q;
    ctrl_d       = ctrl_q;
    prediv_d     = prediv_q;
    raw_d        = raw_q;
    main_d       = main_q;
    main_run_d   = main_run_q;
    prediv_cnt_d = prediv_cnt_q;
    presc_cnt_d  = presc_cnt_q;
    free_d       = free_q;
    free_run_d   = free_run_q;
    fdiv_cnt_d   = fdiv_cnt_q;
    rd_o         = '0;

    case (cmd_i.op)
      ptfc_pkg::OP_TICK: begin
        // main counter holds while stopped or with a zero load
        if (main_run_q && (load_q != '0)) begin
          if (prediv_cnt_q >= prediv_q) begin
            prediv_cnt_d = '0;
            if (presc_cnt_q >= presc_last) begin
              presc_cnt_d = '0;
              if (main_q <= 32'd1) begin
                raw_d  = 1'b1;
                main_d = load_q;
              end else begin
                main_d = main_q - 32'd1;
              end
            end else begin
              presc_cnt_d = presc_cnt_q + 8'd1;
            end
          end else begin
            prediv_cnt_d = prediv_cnt_q + 32'd1;
          end
        end
        if (free_run_q) begin
          if (fdiv_cnt_q >= ctrl_q[23:16]) begin
            fdiv_cnt_d = '0;
            free_d     = (free_q == '0) ? free_lim_cur : free_q - 32'd1;
          end else begin
            fdiv_cnt_d = fdiv_cnt_q + 8'd1;
          end
        end
      end
      ptfc_pkg::OP_READ: begin
        if (known) begin
          case (cmd_i.addr)
            ptfc_pkg::REG_LOAD,
            ptfc_pkg::REG_RELOAD:  rd_o = load_q;
            ptfc_pkg::REG_VALUE:   rd_o = main_q;
            ptfc_pkg::REG_CONTROL: rd_o = ctrl_q;
            ptfc_pkg::REG_INTCLR:  rd_o = ptfc_pkg::ID_WORD;
            ptfc_pkg::REG_RAWIRQ:  rd_o = {31'd0, raw_q};
            ptfc_pkg::REG_MASKIRQ: rd_o = {31'd0, raw_q & ctrl_q[ptfc_pkg::CTRL_INTEN_BIT]};
            ptfc_pkg::REG_FREECNT: rd_o = free_q;
            default:               rd_o = '0;
          endcase
        end
      end
      ptfc_pkg::OP_WRITE: begin
        if (known) begin
          case (cmd_i.addr)
            ptfc_pkg::REG_LOAD: begin
              load_d = cmd_i.wdata;
              main_d = cmd_i.wdata;
            end
            ptfc_pkg::REG_CONTROL: begin
              ctrl_d       = cmd_i.wdata;
              main_run_d   = cmd_i.wdata[ptfc_pkg::CTRL_MAINEN_BIT];
              free_run_d   = cmd_i.wdata[ptfc_pkg::CTRL_FREEEN_BIT];
              prediv_cnt_d = '0;
              presc_cnt_d  = '0;
              fdiv_cnt_d   = '0;
              // restart an enabled counter, clamp a stopped one
              if (main_run_d || (main_q > load_q)) main_d = load_q;
              if (free_run_d || (free_q > free_lim_new)) free_d = free_lim_new;
            end
            ptfc_pkg::REG_INTCLR: raw_d = 1'b0;
            ptfc_pkg::REG_RELOAD: begin
              load_d = cmd_i.wdata;
              if (main_q > cmd_i.wdata) main_d = cmd_i.wdata;
            end
            ptfc_pkg::REG_PREDIV: prediv_d = cmd_i.wdata;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign irq_o = raw_d & ctrl_d[ptfc_pkg::CTRL_INTEN_BIT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q       <= '0;
      ctrl_q       <= ptfc_pkg::CTRL_RESET;
      prediv_q     <= ptfc_pkg::PREDIV_RESET;
      raw_q        <= 1'b0;
      main_q       <= '0;
      main_run_q   <= 1'b0;
      prediv_cnt_q <= '0;
      presc_cnt_q  <= '0;
      free_q       <= '0;
      free_run_q   <= 1'b0;
      fdiv_cnt_q   <= '0;
    end else if (accept_i) begin
      load_q       <= load_d;
      ctrl_q       <= ctrl_d;
      prediv_q     <= prediv_d;
      raw_q        <= raw_d;
      main_q       <= main_d;
      main_run_q   <= main_run_d;
      prediv_cnt_q <= prediv_cnt_d;
      presc_cnt_q  <= presc_cnt_d;
      free_q       <= free_d;
      free_run_q   <= free_run_d;
      fdiv_cnt_q   <= fdiv_cnt_d;
    end
  end

endmodule

### src/periodic_timer_with_free_counter.sv
// Top level of the periodic timer with free-running counter.
// Depends on ptfc_pkg and ptfc_core.
//
// Each input word is a clock tick, a register read or a register write; every
// accepted word yields exactly one result word (read data and interrupt line)
// in the next cycle. One word is taken per cycle unless stalled, since all of
// its work is a single combinational pass through ptfc_core into the output
// register. The input stalls only while that output register holds a result
// that the receiver is stalling. irq_out reflects the state after the word.
module periodic_timer_with_free_counter #(
  parameter int REGISTER_WORDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  word_address_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        irq_out_o
);

  logic           accept;
  ptfc_pkg::cmd_t cmd;
  logic [31:0]    rd;
  logic           irq;
  logic           out_valid_q, out_valid_d;
  logic [31:0]    read_data_q;
  logic           irq_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd.op    = ptfc_pkg::op_e'(operation_i);
  assign cmd.addr  = word_address_i;
  assign cmd.wdata = write_data_i;

  ptfc_core #(
    .REGISTER_WORDS(REGISTER_WORDS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .cmd_i   (cmd),
    .rd_o    (rd),
    .irq_o   (irq)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_data_q <= rd;
      irq_q       <= irq;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign irq_out_o   = irq_q;

endmodule

### src/ptfc_checker.sv
// Port-level checks for the periodic timer; bound to the top level below.
// Depends on ptfc_pkg.
module ptfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  operation_i,
  input logic [5:0]  word_address_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] read_data_o
);

  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_data_o)))
    else $error("stalled result word changed or dropped");

  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (operation_i != ptfc_pkg::OP_READ)) |=> (out_valid_o && (read_data_o == '0)))
    else $error("tick or write word returned nonzero read data");

  a_id_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (operation_i == ptfc_pkg::OP_READ) && (word_address_i == ptfc_pkg::REG_INTCLR))
      |=> (out_valid_o && (read_data_o == ptfc_pkg::ID_WORD)))
    else $error("interrupt clear word read returned wrong id");

endmodule

bind periodic_timer_with_free_counter ptfc_checker u_ptfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .operation_i   (operation_i),
  .word_address_i(word_address_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .read_data_o   (read_data_o)
);
